// ===== sv/fasc_pkg.sv =====
// Package for the fire alarm state controller.
// Holds the alarm state codes, config register indexes and reset values.
// No dependencies.
package fasc_pkg;

   // Alarm state codes
   localparam logic [2:0] ST_NORMAL    = 3'd0;
   localparam logic [2:0] ST_WARNING   = 3'd1;
   localparam logic [2:0] ST_CRITICAL  = 3'd2;
   localparam logic [2:0] ST_EMERGENCY = 3'd3;
   localparam logic [2:0] ST_FAILSAFE  = 3'd4;

   // Config register indexes
   localparam logic [2:0] REG_TEMP_WARN     = 3'd0;
   localparam logic [2:0] REG_SMOKE_WARN    = 3'd1;
   localparam logic [2:0] REG_TEMP_EXTREME  = 3'd2;
   localparam logic [2:0] REG_SMOKE_EXTREME = 3'd3;
   localparam logic [2:0] REG_TEMP_SAFE     = 3'd4;
   localparam logic [2:0] REG_SMOKE_SAFE    = 3'd5;
   localparam logic [2:0] REG_CRIT_TIMEOUT  = 3'd6;

   // Config reset values
   localparam logic signed [15:0] TEMP_WARN_RST     = 16'sd800;
   localparam logic        [11:0] SMOKE_WARN_RST    = 12'd2000;
   localparam logic signed [15:0] TEMP_EXTREME_RST  = 16'sd1120;
   localparam logic        [11:0] SMOKE_EXTREME_RST = 12'd3000;
   localparam logic signed [15:0] TEMP_SAFE_RST     = 16'sd640;
   localparam logic        [11:0] SMOKE_SAFE_RST    = 12'd1500;
   localparam logic        [31:0] CRIT_TIMEOUT_RST  = 32'd10000;

   // One sample held in the input register
   typedef struct packed {
      logic signed [15:0] temp_reading;
      logic        [11:0] smoke_reading;
      logic               temp_failed;
      logic               smoke_failed;
      logic        [31:0] now_ms;
   } sample_type;

endpackage

// ===== sv/fire_alarm_state_controller.sv =====
// Fire alarm state controller: sensor samples in, alarm state and change flag out.
// Depends on fasc_pkg for state codes, register indexes and reset values.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | temp, smoke, two failed flags, now_ms
//   rsp     | out       | rsp_valid/rsp_stall | alarm_state, state_changed
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// One sample per cycle sustained while the result is not stalled; a sample passes
// from the input register through one pass of compare and state update into the
// result register, from which its result can be taken.
// The alarm state advances when the sample moves from input to result register.
// Reset (synchronous) returns the state to normal, clears the timer, reloads config.
// A stalled result holds; the input register keeps taking words while it can drain.
module fire_alarm_state_controller
   import fasc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_temp_reading,
   input  logic        [11:0] req_smoke_reading,
   input  logic               req_temp_failed,
   input  logic               req_smoke_failed,
   input  logic        [31:0] req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [2:0]  rsp_alarm_state,
   output logic               rsp_state_changed,
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   // Config registers
   logic signed [15:0] temp_warn_ff;
   logic        [11:0] smoke_warn_ff;
   logic signed [15:0] temp_ext_ff;
   logic        [11:0] smoke_ext_ff;
   logic signed [15:0] temp_safe_ff;
   logic        [11:0] smoke_safe_ff;
   logic        [31:0] crit_timeout_ff;

   // Pipeline and state registers
   logic        in_vld_ff;
   sample_type  in_ff;
   logic        out_vld_ff;
   logic [2:0]  out_state_ff;
   logic        out_changed_ff;
   logic [2:0]  alarm_ff;
   logic [2:0]  alarm_in;
   logic [31:0] entry_ff;
   logic [31:0] entry_in;

   logic        advance;
   logic        req_take;
   logic        changed;
   logic        t_warn, s_warn, t_ext, s_ext, t_safe, s_safe;
   logic [31:0] elapsed;

   // Move the held sample on when the result register is empty or draining
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Write config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_warn_ff    <= TEMP_WARN_RST;
         smoke_warn_ff   <= SMOKE_WARN_RST;
         temp_ext_ff     <= TEMP_EXTREME_RST;
         smoke_ext_ff    <= SMOKE_EXTREME_RST;
         temp_safe_ff    <= TEMP_SAFE_RST;
         smoke_safe_ff   <= SMOKE_SAFE_RST;
         crit_timeout_ff <= CRIT_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEMP_WARN:     temp_warn_ff    <= csr_wdata[15:0];
            REG_SMOKE_WARN:    smoke_warn_ff   <= csr_wdata[11:0];
            REG_TEMP_EXTREME:  temp_ext_ff     <= csr_wdata[15:0];
            REG_SMOKE_EXTREME: smoke_ext_ff    <= csr_wdata[11:0];
            REG_TEMP_SAFE:     temp_safe_ff    <= csr_wdata[15:0];
            REG_SMOKE_SAFE:    smoke_safe_ff   <= csr_wdata[11:0];
            REG_CRIT_TIMEOUT:  crit_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.temp_reading  <= req_temp_reading;
         in_ff.smoke_reading <= req_smoke_reading;
         in_ff.temp_failed   <= req_temp_failed;
         in_ff.smoke_failed  <= req_smoke_failed;
         in_ff.now_ms        <= req_now_ms;
      end
   end

   // Threshold compares; a failed sensor reads below every level
   always_comb begin
      t_warn  = !in_ff.temp_failed  && (in_ff.temp_reading > temp_warn_ff);
      s_warn  = !in_ff.smoke_failed && (in_ff.smoke_reading > smoke_warn_ff);
      t_ext   = !in_ff.temp_failed  && (in_ff.temp_reading > temp_ext_ff);
      s_ext   = !in_ff.smoke_failed && (in_ff.smoke_reading > smoke_ext_ff);
      t_safe  = in_ff.temp_failed   || (in_ff.temp_reading < temp_safe_ff);
      s_safe  = in_ff.smoke_failed  || (in_ff.smoke_reading < smoke_safe_ff);
      elapsed = in_ff.now_ms - entry_ff;
   end

   // Pick the next alarm state and update the critical timer
   always_comb begin
      if (in_ff.temp_failed && in_ff.smoke_failed) begin
         alarm_in = ST_FAILSAFE;
      end else if (alarm_ff == ST_EMERGENCY) begin
         alarm_in = (t_safe && s_safe) ? ST_NORMAL : ST_EMERGENCY;
      end else if ((t_ext && s_ext) ||
                   (alarm_ff == ST_CRITICAL && t_warn && s_warn &&
                    elapsed > crit_timeout_ff)) begin
         alarm_in = ST_EMERGENCY;
      end else if (t_warn && s_warn) begin
         alarm_in = ST_CRITICAL;
      end else if (t_warn || s_warn) begin
         alarm_in = ST_WARNING;
      end else begin
         alarm_in = ST_NORMAL;
      end
      changed = (alarm_in != alarm_ff);
      if (!changed) begin
         entry_in = entry_ff;
      end else if (alarm_in == ST_CRITICAL) begin
         entry_in = in_ff.now_ms;
      end else begin
         entry_in = '0;
      end
   end

   // Advance the alarm state once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= ST_NORMAL;
         entry_ff <= '0;
      end else if (advance) begin
         alarm_ff <= alarm_in;
         entry_ff <= entry_in;
      end
   end

   // Result register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff   <= alarm_in;
         out_changed_ff <= changed;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_alarm_state   = out_state_ff;
   assign rsp_state_changed = out_changed_ff;

   // Checks
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("input stalled with an empty input register");

   a_timer_only_in_critical: assert property (@(posedge clock) disable iff (reset)
      (alarm_ff != ST_CRITICAL) |-> (entry_ff == 32'd0))
      else $error("critical timer set outside critical");

   a_failsafe_on_both_failed: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.temp_failed && in_ff.smoke_failed) |=>
         (alarm_ff == ST_FAILSAFE && out_state_ff == ST_FAILSAFE))
      else $error("both sensors failed but not fail-safe");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_changed_ff == (alarm_ff != $past(alarm_ff))))
      else $error("change flag does not match state update");

endmodule
